// ----- sv/nzce_pkg.sv -----
// Shared constants, codes and types of the nonzero coordinate extractor.
package nzce_pkg;

    // Tensor shape limits
    localparam int MAX_RANK    = 6;
    localparam int EXTENT_BITS = 16;
    localparam int ERANK_W     = $clog2(MAX_RANK + 1);

    // Fixed field widths
    localparam int NUM_COORDS  = 6;
    localparam int COORD_W     = 16;
    localparam int COUNT_W     = 32;
    localparam int ELEM_W      = 32;
    localparam int KIND_W      = 3;
    localparam int RANK_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Result queue size
    localparam int RQ_DEPTH    = 4;
    localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W    = $clog2(RQ_DEPTH + 1);

    // Element encodings; the eighth code compares all bits like i32
    typedef enum logic [KIND_W-1:0] {
        KIND_F32  = 3'd0,
        KIND_BF16 = 3'd1,
        KIND_F16  = 3'd2,
        KIND_I32  = 3'd3,
        KIND_U32  = 3'd4,
        KIND_I8   = 3'd5,
        KIND_U8   = 3'd6
    } t_kind;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND     = 3'd0,
        REG_RANK     = 3'd1,
        REG_EXTENT_0 = 3'd2,
        REG_EXTENT_1 = 3'd3,
        REG_EXTENT_2 = 3'd4,
        REG_EXTENT_3 = 3'd5,
        REG_EXTENT_4 = 3'd6,
        REG_EXTENT_5 = 3'd7
    } t_cfg_reg;

    typedef logic [COORD_W-1:0]     t_coord;
    typedef logic [EXTENT_BITS-1:0] t_extent;

    // One result beat as held in the queue
    typedef struct packed {
        t_coord [NUM_COORDS-1:0] coord;
        logic [COUNT_W-1:0]      pos;
        logic                    summary;
    } t_result;

    // Up to two results pushed per accepted element; e1 only with e0
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result e0;
        t_result e1;
    } t_rq_push;

endpackage

// ----- sv/nzce_coord.sv -----
// Coordinate counters with carry-chain advance and the nonzero tally.
module nzce_coord
    import nzce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_nonzero,
    input  logic                 i_last,
    input  logic [ERANK_W-1:0]   i_rank,
    input  t_extent              i_extent [MAX_RANK],
    output t_extent              o_pos [MAX_RANK],
    output logic [COUNT_W-1:0]   o_tally
);

    t_extent              r_pos [MAX_RANK];
    t_extent              n_pos [MAX_RANK];
    logic [COUNT_W-1:0]   r_tally;
    logic [COUNT_W-1:0]   n_tally;

    // Step the innermost active dimension, ripple the wrap outward
    always_comb begin
        logic                 carry;
        logic                 wrap;
        logic [EXTENT_BITS:0] inc_v;
        t_extent              ext_eff;
        carry = 1'b1;
        for (int d = MAX_RANK - 1; d >= 0; d--) begin
            n_pos[d] = r_pos[d];
            ext_eff  = (i_extent[d] == '0) ? t_extent'(1) : i_extent[d];
            inc_v    = {1'b0, r_pos[d]} + (EXTENT_BITS + 1)'(1);
            wrap     = (inc_v >= {1'b0, ext_eff});
            if (d < int'(i_rank)) begin
                if (carry) begin
                    n_pos[d] = wrap ? '0 : inc_v[EXTENT_BITS-1:0];
                end
                carry = carry & wrap;
            end
        end
        n_tally = r_tally + COUNT_W'(i_nonzero);
        // Drop all state at the end of a tensor
        if (i_last) begin
            for (int d = 0; d < MAX_RANK; d++) begin
                n_pos[d] = '0;
            end
            n_tally = '0;
        end
    end

    // Advance on every accepted element beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_RANK; d++) begin
                r_pos[d] <= '0;
            end
            r_tally <= '0;
        end else if (i_adv) begin
            r_pos   <= n_pos;
            r_tally <= n_tally;
        end
    end

    assign o_pos   = r_pos;
    assign o_tally = r_tally;

endmodule

// ----- sv/nzce_rq.sv -----
// Small result queue: up to two pushes and one pop per cycle.
module nzce_rq
    import nzce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rq_push i_push,
    output logic     o_room,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_head
);

    t_result              r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  r_wr_ptr;
    logic [RQ_PTR_W-1:0]  r_rd_ptr;
    logic [RQ_CNT_W-1:0]  r_count;
    logic [RQ_PTR_W-1:0]  n_wr_ptr;
    logic [RQ_PTR_W-1:0]  n_rd_ptr;
    logic [RQ_CNT_W-1:0]  n_count;
    logic [RQ_PTR_W-1:0]  wr_ptr_1;
    logic [1:0]           push_n;
    logic                 pop;

    assign pop      = (r_count != '0) && i_ready;
    assign push_n   = {1'b0, i_push.push0} + {1'b0, i_push.push1};
    assign wr_ptr_1 = r_wr_ptr + RQ_PTR_W'(1);
    assign n_wr_ptr = r_wr_ptr + RQ_PTR_W'(push_n);
    assign n_rd_ptr = r_rd_ptr + RQ_PTR_W'(pop);
    assign n_count  = r_count + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.e0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr_1] <= i_push.e1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Room for a worst-case element (two results)
    assign o_room  = (r_count <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ----- sv/nonzero_coordinate_extractor_top.sv -----
// Top level of the nonzero coordinate extractor.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+----------------------------------------
//   element  | i_in_valid / o_in_ready        | i_element_bits, i_final_element
//   result   | o_out_valid / i_out_ready      | o_coord_0..5, o_list_position,
//            |                                | o_is_summary, o_total_nonzero
//   config   | i_cfg_we (no wait)             | i_cfg_index, i_cfg_data
//
// One element beat is taken per cycle while the queue has room. An element yields zero,
// one or two result beats into a four-entry result queue, so with one result per element
// and i_out_ready held high the sustained rate is one element per cycle; a final nonzero
// element also pushes a summary beat behind its result. o_in_ready depends only on
// queue fill, never on i_out_ready. Synchronous active-low reset clears counters,
// tally and queue, and returns the config registers to their defaults.
module nonzero_coordinate_extractor_top
    import nzce_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [ELEM_W-1:0]       i_element_bits,
    input  logic                    i_final_element,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [COORD_W-1:0]      o_coord_0,
    output logic [COORD_W-1:0]      o_coord_1,
    output logic [COORD_W-1:0]      o_coord_2,
    output logic [COORD_W-1:0]      o_coord_3,
    output logic [COORD_W-1:0]      o_coord_4,
    output logic [COORD_W-1:0]      o_coord_5,
    output logic [COUNT_W-1:0]      o_list_position,
    output logic                    o_is_summary,
    output logic [COUNT_W-1:0]      o_total_nonzero
);

    logic [KIND_W-1:0]    r_kind;
    logic [RANK_W-1:0]    r_rank;
    t_extent              r_extent [MAX_RANK];

    logic                 accept;
    logic                 nonzero;
    logic [ERANK_W-1:0]   erank;
    t_extent              pos [MAX_RANK];
    logic [COUNT_W-1:0]   tally;
    t_result              elem_res;
    t_result              sum_res;
    t_rq_push             push;
    t_result              head;
    logic                 room;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_W'(KIND_F32);
            r_rank <= RANK_W'(1);
            for (int d = 0; d < MAX_RANK; d++) begin
                r_extent[d] <= t_extent'(1);
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_KIND: r_kind <= i_cfg_data[KIND_W-1:0];
                REG_RANK: r_rank <= i_cfg_data[RANK_W-1:0];
                REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2,
                REG_EXTENT_3, REG_EXTENT_4, REG_EXTENT_5: begin
                    for (int d = 0; d < MAX_RANK; d++) begin
                        if (d == int'(i_cfg_index) - int'(REG_EXTENT_0)) begin
                            r_extent[d] <= t_extent'(i_cfg_data);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Clamp rank to the supported dimension count
    assign erank = (int'(r_rank) > MAX_RANK) ? ERANK_W'(MAX_RANK) : ERANK_W'(r_rank);

    // Zero test per element kind; signed float zeros are zero
    always_comb begin
        unique case (t_kind'(r_kind))
            KIND_F32:            nonzero = (i_element_bits[30:0] != '0);
            KIND_BF16, KIND_F16: nonzero = (i_element_bits[14:0] != '0);
            KIND_I8, KIND_U8:    nonzero = (i_element_bits[7:0] != '0);
            default:             nonzero = (i_element_bits != '0);
        endcase
    end

    assign accept     = i_in_valid && room;
    assign o_in_ready = room;

    nzce_coord u_coord (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (accept),
        .i_nonzero (nonzero),
        .i_last    (i_final_element),
        .i_rank    (erank),
        .i_extent  (r_extent),
        .o_pos     (pos),
        .o_tally   (tally)
    );

    // Build element and summary results
    always_comb begin
        elem_res = '0;
        for (int j = 0; j < NUM_COORDS; j++) begin
            if (j < MAX_RANK && j < int'(erank)) begin
                elem_res.coord[j] = COORD_W'(pos[j]);
            end
        end
        elem_res.pos     = tally;
        elem_res.summary = 1'b0;

        sum_res         = '0;
        sum_res.pos     = tally + COUNT_W'(nonzero);
        sum_res.summary = 1'b1;
    end

    // Pack the pushes; the summary always follows the element result
    always_comb begin
        logic has_elem;
        logic has_sum;
        has_elem   = accept && nonzero && (erank != '0);
        has_sum    = accept && i_final_element;
        push.push0 = has_elem || has_sum;
        push.push1 = has_elem && has_sum;
        push.e0    = has_elem ? elem_res : sum_res;
        push.e1    = sum_res;
    end

    nzce_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    // Drive result fields from the queue head
    assign o_coord_0       = head.coord[0];
    assign o_coord_1       = head.coord[1];
    assign o_coord_2       = head.coord[2];
    assign o_coord_3       = head.coord[3];
    assign o_coord_4       = head.coord[4];
    assign o_coord_5       = head.coord[5];
    assign o_list_position = head.pos;
    assign o_is_summary    = head.summary;
    assign o_total_nonzero = head.summary ? head.pos : '0;

endmodule
